[hdl/sdq_pkg.sv]
package sdq_pkg;

  localparam int DEPTH      = 64;
  localparam int ID_BITS    = 10;
  localparam int DL_BITS    = 32;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_POP    = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ID_BITS-1:0] client_id;
    logic [DL_BITS-1:0] deadline;
  } req_beat_t;

  typedef struct packed {
    logic                  head_valid;
    logic [ID_BITS-1:0]    head_client;
    logic [DL_BITS-1:0]    head_deadline;
    logic [COUNT_BITS-1:0] occupancy;
    logic                  dropped;
  } resp_beat_t;

  typedef struct packed {
    logic               valid;
    logic [ID_BITS-1:0] client;
    logic [DL_BITS-1:0] deadline;
  } entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic               clr;
    logic               rem;
    logic               match_en;
    logic               ins;
    logic [ID_BITS-1:0] id;
    logic [DL_BITS-1:0] dl;
  } cell_ctrl_t;

endpackage

[hdl/sdq_cell.sv]
module sdq_cell (
  input  logic               clk,
  input  logic               rst,
  input  sdq_pkg::cell_ctrl_t ctrl,
  input  sdq_pkg::entry_t    prev,
  input  sdq_pkg::entry_t    next,
  input  logic               shift_in,
  input  logic               gt_in,
  output logic               shift_out,
  output logic               gt_out,
  output sdq_pkg::entry_t    ent
);
  import sdq_pkg::*;

  logic kill;

  // A removal shifts this cell and every cell behind the matching one.
  assign kill      = ctrl.match_en && ent.valid && (ent.client == ctrl.id);
  assign shift_out = shift_in | kill;

  // Empty cells count as later than any deadline, so the new entry lands
  // in the first cell whose deadline is strictly greater or that is empty.
  assign gt_out = !ent.valid || (ent.deadline > ctrl.dl);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctrl.clr) begin
      ent.valid <= 1'b0;
    end else if (ctrl.rem && shift_out) begin
      ent <= next;
    end else if (ctrl.ins && gt_out) begin
      ent.valid    <= gt_in ? prev.valid : 1'b1;
      ent.client   <= gt_in ? prev.client : ctrl.id;
      ent.deadline <= gt_in ? prev.deadline : ctrl.dl;
    end
  end

endmodule

[hdl/sorted_deadline_queue.sv]
// Channel   Signals                              Beat
// request   in_valid, in_ready, in_data          req_type, client_id, deadline
// response  out_valid, out_ready, out_data       head, occupancy, dropped
//
// Each request runs in two steps: one removal step and one insertion step in
// the chain of DEPTH cells, each step a local compare and a neighbor shift.
// A new request is taken during the insertion step of the previous one.
// The response is loaded from a pending flag set in the insertion step; while
// the output register is still full, the removal step of the next request waits.
// Reset empties every cell and clears the count and the output valid; the
// input is ready from the first cycle after reset.
module sorted_deadline_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdq_pkg::req_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdq_pkg::resp_beat_t out_data
);
  import sdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REMOVE = 3'b010,
    S_INSERT = 3'b100
  } state_t;

  state_t                state, state_next;
  req_beat_t             req;
  logic [COUNT_BITS-1:0] count;
  logic                  pend;
  logic                  pend_drop;
  logic                  accept;
  logic                  out_load;
  logic                  can_go;
  logic                  do_insert;
  cell_ctrl_t            ctrl;

  entry_t ent     [DEPTH];
  entry_t prev_e  [DEPTH];
  entry_t next_e  [DEPTH];
  logic   shift_c [DEPTH+1];
  logic   gt_c    [DEPTH+1];

  assign in_ready = (state == S_IDLE) || (state == S_INSERT);
  assign accept   = in_valid && in_ready;
  assign out_load = pend && (!out_valid || out_ready);
  assign can_go   = !pend || out_load;
  assign do_insert = (req.req_type == REQ_UPDATE) && (count < COUNT_BITS'(DEPTH));

  // A pop shifts the whole chain when it holds anything.
  assign shift_c[0] = (state == S_REMOVE) && can_go && (req.req_type == REQ_POP) &&
                      (count != '0);
  assign gt_c[0]    = 1'b0;

  always_comb begin
    ctrl          = '0;
    ctrl.id       = req.client_id;
    ctrl.dl       = req.deadline;
    if (state == S_REMOVE && can_go) begin
      unique case (req.req_type)
        REQ_UPDATE, REQ_REMOVE: begin
          ctrl.rem      = 1'b1;
          ctrl.match_en = 1'b1;
        end
        REQ_POP: begin
          ctrl.rem = 1'b1;
        end
        REQ_CLEAR: ctrl.clr = 1'b1;
        default: ctrl.clr = 1'b0;
      endcase
    end
    if (state == S_INSERT) begin
      ctrl.ins = do_insert;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_e[i] = '0;
    end else begin : g_mid
      assign prev_e[i] = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_e[i] = '0;
    end else begin : g_inner
      assign next_e[i] = ent[i+1];
    end
    sdq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev      (prev_e[i]),
      .next      (next_e[i]),
      .shift_in  (shift_c[i]),
      .gt_in     (gt_c[i]),
      .shift_out (shift_c[i+1]),
      .gt_out    (gt_c[i+1]),
      .ent       (ent[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_REMOVE;
      S_REMOVE: if (can_go) state_next = S_INSERT;
      S_INSERT: state_next = accept ? S_REMOVE : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      pend_drop <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.clr) begin
        count <= '0;
      end else if (ctrl.rem && shift_c[DEPTH]) begin
        count <= count - COUNT_BITS'(1);
      end else if (ctrl.ins) begin
        count <= count + COUNT_BITS'(1);
      end
      if (state == S_INSERT) begin
        pend      <= 1'b1;
        pend_drop <= (req.req_type == REQ_UPDATE) && !do_insert;
      end else if (out_load) begin
        pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (out_load) begin
      out_data.head_valid    <= (count != '0);
      out_data.head_client   <= (count != '0) ? ent[0].client : '0;
      out_data.head_deadline <= (count != '0) ? ent[0].deadline : '0;
      out_data.occupancy     <= count;
      out_data.dropped       <= pend_drop;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(DEPTH))
    else $error("entry count above depth");

  a_remove_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_REMOVE && !can_go) |=> (state == S_REMOVE))
    else $error("removal step ran before the pending response was loaded");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && out_data.occupancy == $past(count)))
    else $error("response occupancy does not match the chain");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.head_valid == (out_data.occupancy != '0)))
    else $error("head valid disagrees with occupancy");

endmodule
